>>> rtl/core/assert_macros.svh
// Assertion macros used by the decoder RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DQD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DQD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/dqd_pkg.sv
// Shared types, codes and the phase step table of the dual quadrature decoder.
// No dependencies.
package dqd_pkg;

	localparam int CNT_W     = 16;
	localparam int PCT_W     = 7;
	localparam int DVD_W     = 23;
	localparam int PCT_SCALE = 100;
	localparam int PCT_MAX   = 100;
	localparam logic [CNT_W-1:0] MAX_RESET = 16'd1000;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_ZERO1  = 2'd1;
	localparam logic [1:0] OP_ZERO2  = 2'd2;

	localparam logic REG_MAX_A = 1'b0;
	localparam logic REG_MAX_B = 1'b1;

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2,
		STEP_BAD  = 2'd3
	} step_t;

	// phase codes are {B, A}
	function automatic step_t step_code(input logic [1:0] now, input logic [1:0] last);
		step_t s;
		case ({now, last})
			4'd0:    s = STEP_NONE;
			4'd1:    s = STEP_UP;
			4'd2:    s = STEP_DOWN;
			4'd3:    s = STEP_BAD;
			4'd4:    s = STEP_DOWN;
			4'd5:    s = STEP_NONE;
			4'd6:    s = STEP_BAD;
			4'd7:    s = STEP_UP;
			4'd8:    s = STEP_UP;
			4'd9:    s = STEP_BAD;
			4'd10:   s = STEP_NONE;
			4'd11:   s = STEP_DOWN;
			4'd12:   s = STEP_BAD;
			4'd13:   s = STEP_DOWN;
			4'd14:   s = STEP_UP;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/dqd_track.sv
// One quadrature channel: last phase, clamped count, invalid step flag.
// Depends on dqd_pkg.
module dqd_track (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_en,
	input  logic                      zero_en,
	input  logic [1:0]                phase,
	input  logic [dqd_pkg::CNT_W-1:0] max_count,
	output logic [dqd_pkg::CNT_W-1:0] count,
	output logic                      bad
);
	import dqd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [1:0]       last_q;
	step_t            code;
	logic [CNT_W:0]   nxt;
	logic [CNT_W-1:0] clamped;

	always_comb begin
		code = step_code(phase, last_q);
		case (code)
			STEP_UP:   nxt = {1'b0, count_q} + (CNT_W+1)'(1);
			STEP_DOWN: nxt = (count_q == '0) ? '0 : {1'b0, count_q} - (CNT_W+1)'(1);
			default:   nxt = {1'b0, count_q};
		endcase
		clamped = (nxt > {1'b0, max_count}) ? max_count : nxt[CNT_W-1:0];
	end

	assign bad   = sample_en && (code == STEP_BAD);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			last_q  <= 2'd0;
		end else if (sample_en) begin
			count_q <= clamped;
			last_q  <= phase;
		end else if (zero_en) begin
			count_q <= CNT_W'(1);
		end
	end

endmodule

>>> rtl/core/dqd_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dqd_pkg.
module dqd_serdiv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dqd_pkg::DVD_W-1:0] dividend,
	input  logic [dqd_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [dqd_pkg::DVD_W-1:0] quotient
);
	import dqd_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvr_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;

	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign diff     = trial - {1'b0, dvr_q};
	assign fits     = trial >= {1'b0, dvr_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvr_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

endmodule

>>> rtl/core/dual_quadrature_decoder.sv
// Dual 4x quadrature decoder with serial percent and target scaling.
// An accepted word passes LOAD (divider start), DIV (until the dividers finish) and WAIT (output register load).
// A new word is accepted only in IDLE, once the previous result has entered the output register.
// The output register lets a result wait while the next word is taken in.
// Reset (arst_n, async low): counts 1, last phases 0, glitch total 0, maxima 1000.
// Depends on dqd_pkg, dqd_track, dqd_serdiv, assert_macros.svh.
`include "assert_macros.svh"
module dual_quadrature_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] enc1_phase_a, [1] enc1_phase_b, [2] enc2_phase_a, [3] enc2_phase_b,
	// [4] limit1_n, [5] limit2_n, [13:6] target_percent, [15:14] zero
	input  logic [15:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] count_one, [31:16] count_two, [38:32] percent_one, [45:39] percent_two,
	// [61:46] glitch_total, [62] at_limit_one, [63] at_limit_two,
	// [79:64] target_count_one, [95:80] target_count_two
	output logic [95:0] m_tdata
);
	import dqd_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] max_a_q, max_b_q;
	logic [CNT_W-1:0] glitch_q;
	logic [PCT_W-1:0] pct_sat_q;
	logic             lim1_q, lim2_q;
	logic             maxz1_q, maxz2_q;
	logic             m_valid_q;
	logic [95:0]      m_data_q;

	logic             accept, start, load_out;
	logic             bad1, bad2;
	logic [CNT_W-1:0] count_one, count_two;
	logic [PCT_W-1:0] pct_in;
	logic [DVD_W-1:0] q_p1, q_p2, q_t1, q_t2;
	logic             done_p1, done_p2, done_t1, done_t2;
	logic [PCT_W-1:0] percent_one, percent_two;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign start    = (state_q == ST_LOAD);
	assign load_out = (state_q == ST_WAIT) && (!m_valid_q || m_tready);
	assign pct_in   = (s_tdata[13:6] > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : s_tdata[12:6];

	dqd_track u_track1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (accept && (s_tuser == OP_SAMPLE)),
		.zero_en   (accept && (s_tuser == OP_ZERO1)),
		.phase     (s_tdata[1:0]),
		.max_count (max_a_q),
		.count     (count_one),
		.bad       (bad1)
	);

	dqd_track u_track2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_en (accept && (s_tuser == OP_SAMPLE)),
		.zero_en   (accept && (s_tuser == OP_ZERO2)),
		.phase     (s_tdata[3:2]),
		.max_count (max_b_q),
		.count     (count_two),
		.bad       (bad2)
	);

	dqd_serdiv u_div_p1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (DVD_W'(count_one) * DVD_W'(PCT_SCALE)),
		.divisor  (max_a_q),
		.done     (done_p1),
		.quotient (q_p1)
	);

	dqd_serdiv u_div_p2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (DVD_W'(count_two) * DVD_W'(PCT_SCALE)),
		.divisor  (max_b_q),
		.done     (done_p2),
		.quotient (q_p2)
	);

	dqd_serdiv u_div_t1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (DVD_W'(pct_sat_q) * DVD_W'(max_a_q)),
		.divisor  (CNT_W'(PCT_SCALE)),
		.done     (done_t1),
		.quotient (q_t1)
	);

	dqd_serdiv u_div_t2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (DVD_W'(pct_sat_q) * DVD_W'(max_b_q)),
		.divisor  (CNT_W'(PCT_SCALE)),
		.done     (done_t2),
		.quotient (q_t2)
	);

	always_comb begin
		if (maxz1_q)
			percent_one = '0;
		else if (q_p1 > DVD_W'(PCT_MAX))
			percent_one = PCT_W'(PCT_MAX);
		else
			percent_one = q_p1[PCT_W-1:0];
		if (maxz2_q)
			percent_two = '0;
		else if (q_p2 > DVD_W'(PCT_MAX))
			percent_two = PCT_W'(PCT_MAX);
		else
			percent_two = q_p2[PCT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_a_q   <= MAX_RESET;
			max_b_q   <= MAX_RESET;
			glitch_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_A: max_a_q <= cfg_data;
					REG_MAX_B: max_b_q <= cfg_data;
					default:   max_a_q <= max_a_q;
				endcase
			end
			if (accept)
				glitch_q <= glitch_q + CNT_W'(bad1) + CNT_W'(bad2);
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV:  if (done_p1) state_q <= ST_WAIT;
				ST_WAIT: if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (load_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pct_sat_q <= pct_in;
			lim1_q    <= ~s_tdata[4];
			lim2_q    <= ~s_tdata[5];
		end
		if (start) begin
			maxz1_q <= (max_a_q == '0);
			maxz2_q <= (max_b_q == '0);
		end
		if (load_out)
			m_data_q <= {q_t2[CNT_W-1:0], q_t1[CNT_W-1:0], lim2_q, lim1_q, glitch_q,
				percent_two, percent_one, count_two, count_one};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	`DQD_ASSERT_NEXT(a_accept_loads, accept, state_q == ST_LOAD, "accept did not start a load")
	`DQD_ASSERT(a_done_in_div, (done_p1 || done_p2 || done_t1 || done_t2) |-> (state_q == ST_DIV && done_p1 && done_p2 && done_t1 && done_t2), "divider lanes out of step")
	`DQD_ASSERT_NEXT(a_glitch_hold, !accept, $stable(glitch_q), "glitch total moved without a word")
	`DQD_ASSERT(a_pct_range, m_tvalid |-> (m_tdata[38:32] <= 7'd100 && m_tdata[45:39] <= 7'd100), "percent above full scale")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for dual_quadrature_decoder: phase steps, clamps, glitch count,
// percent and target scaling under random stream stalls and register changes.
// Depends on dqd_pkg and the decoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dqd_pkg::*;

	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int MAX_GAP = 18;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 150;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] ph1;    // {B, A}
		logic [1:0] ph2;
		logic       lim1_n;
		logic       lim2_n;
		logic [7:0] pct;
	} sample_t;

	// highest field first so that it maps straight onto m_tdata
	typedef struct packed {
		logic [15:0] tgt2;
		logic [15:0] tgt1;
		logic        lim2;
		logic        lim1;
		logic [15:0] glitches;
		logic [6:0]  pct2;
		logic [6:0]  pct1;
		logic [15:0] cnt2;
		logic [15:0] cnt1;
	} position_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	dual_quadrature_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// decoder state as the block should hold it
	logic [15:0] max_a, max_b;
	logic [15:0] pos1, pos2;
	logic [1:0]  last1, last2;
	logic [15:0] glitch_cnt;

	position_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int hold_len = 0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;

	// position of a {B, A} code along the Gray sequence 00, 01, 11, 10
	function automatic logic [1:0] gray_pos(logic [1:0] ph);
		return {ph[1], ph[1] ^ ph[0]};
	endfunction

	function automatic logic [1:0] phase_at(logic [1:0] g);
		return {g[1], g[1] ^ g[0]};
	endfunction

	function automatic step_t phase_step(logic [1:0] now, logic [1:0] prev);
		logic [1:0] d;
		d = gray_pos(prev) - gray_pos(now);
		case (d)
			2'd0: return STEP_NONE;
			2'd1: return STEP_UP;
			2'd2: return STEP_BAD;
			default: return STEP_DOWN;
		endcase
	endfunction

	function automatic logic [1:0] phase_after(logic [1:0] prev, logic up);
		return up ? phase_at(gray_pos(prev) - 2'd1) : phase_at(gray_pos(prev) + 2'd1);
	endfunction

	function automatic logic [15:0] track_encoder(logic [15:0] cnt, logic [1:0] now,
			logic [1:0] prev, logic [15:0] lim);
		logic [16:0] nxt;
		nxt = {1'b0, cnt};
		case (phase_step(now, prev))
			STEP_UP: nxt = {1'b0, cnt} + 17'd1;
			STEP_DOWN: if (cnt != 16'd0) nxt = {1'b0, cnt} - 17'd1;
			STEP_BAD: glitch_cnt = glitch_cnt + 16'd1;
			default: ;
		endcase
		if (nxt > {1'b0, lim})
			nxt = {1'b0, lim};
		return nxt[15:0];
	endfunction

	function automatic logic [6:0] percent_of_travel(logic [15:0] cnt, logic [15:0] lim);
		int unsigned p;
		if (lim == 16'd0)
			return 7'd0;
		p = (32'(cnt) * 32'd100) / 32'(lim);
		return (p > 100) ? 7'd100 : p[6:0];
	endfunction

	function automatic logic [15:0] travel_of_percent(logic [7:0] pct, logic [15:0] lim);
		int unsigned p;
		p = (pct > 8'd100) ? 100 : 32'(pct);
		return 16'((p * 32'(lim)) / 100);
	endfunction

	function automatic position_t decode_sample(sample_t w);
		position_t r;
		case (w.op)
			OP_SAMPLE: begin
				pos1 = track_encoder(pos1, w.ph1, last1, max_a);
				pos2 = track_encoder(pos2, w.ph2, last2, max_b);
				last1 = w.ph1;
				last2 = w.ph2;
			end
			OP_ZERO1: pos1 = 16'd1;
			OP_ZERO2: pos2 = 16'd1;
			default: ;
		endcase
		r.cnt1 = pos1;
		r.cnt2 = pos2;
		r.pct1 = percent_of_travel(pos1, max_a);
		r.pct2 = percent_of_travel(pos2, max_b);
		r.glitches = glitch_cnt;
		r.lim1 = ~w.lim1_n;
		r.lim2 = ~w.lim2_n;
		r.tgt1 = travel_of_percent(w.pct, max_a);
		r.tgt2 = travel_of_percent(w.pct, max_b);
		return r;
	endfunction

	function automatic sample_t make_sample(logic [1:0] op, logic [1:0] ph1, logic [1:0] ph2,
			logic [1:0] lim_n, logic [7:0] pct);
		sample_t w;
		w.op = op;
		w.ph1 = ph1;
		w.ph2 = ph2;
		w.lim1_n = lim_n[0];
		w.lim2_n = lim_n[1];
		w.pct = pct;
		return w;
	endfunction

	// mostly clean steps in the chosen direction, some holds, reversals and double steps
	function automatic logic [1:0] move_encoder(logic [1:0] prev, logic up);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return phase_at(gray_pos(prev) + 2'd2);
		if (r < 20)
			return prev;
		return phase_after(prev, up ^ (r >= 90));
	endfunction

	function automatic sample_t motion_sample(logic up1, logic up2);
		sample_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 88)
			w.op = OP_SAMPLE;
		else if (r < 92)
			w.op = OP_ZERO1;
		else if (r < 96)
			w.op = OP_ZERO2;
		else
			w.op = OP_IGNORED;
		if ($urandom_range(0, 19) == 0) begin
			w.ph1 = 2'($urandom);
			w.ph2 = 2'($urandom);
		end else begin
			w.ph1 = move_encoder(last1, up1);
			w.ph2 = move_encoder(last2, up2);
		end
		w.lim1_n = 1'($urandom);
		w.lim2_n = 1'($urandom);
		w.pct = $urandom_range(0, 1) ? 8'($urandom_range(0, 100)) : 8'($urandom);
		return w;
	endfunction

	task automatic send_sample(sample_t w);
		int gap;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, w.pct, w.lim2_n, w.lim1_n, w.ph2[1], w.ph2[0], w.ph1[1], w.ph1[0]};
		s_tuser <= w.op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_q.push_back(decode_sample(w));
	endtask

	// sender stops and waits until every result is back
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_max(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_A)
			max_a = val;
		else
			max_b = val;
	endtask

	task automatic set_travel(logic [15:0] a, logic [15:0] b);
		quiesce();
		write_max(REG_MAX_A, a);
		write_max(REG_MAX_B, b);
	endtask

	task automatic test_phase_table();
		send_sample(make_sample(OP_IGNORED, 2'b11, 2'b11, 2'b11, 8'd255));
		send_sample(make_sample(OP_SAMPLE, 2'b01, 2'b10, 2'b00, 8'd0));
		send_sample(make_sample(OP_SAMPLE, 2'b11, 2'b11, 2'b01, 8'd100));
		send_sample(make_sample(OP_SAMPLE, 2'b10, 2'b01, 2'b10, 8'd101));
		send_sample(make_sample(OP_SAMPLE, 2'b00, 2'b00, 2'b11, 8'd50));
		send_sample(make_sample(OP_SAMPLE, 2'b00, 2'b00, 2'b00, 8'd99));
		send_sample(make_sample(OP_SAMPLE, 2'b11, 2'b11, 2'b01, 8'd1));
		send_sample(make_sample(OP_SAMPLE, 2'b00, 2'b00, 2'b10, 8'd200));
		send_sample(make_sample(OP_SAMPLE, 2'b10, 2'b01, 2'b11, 8'd170));
		send_sample(make_sample(OP_ZERO1, 2'b11, 2'b00, 2'b00, 8'd85));
		send_sample(make_sample(OP_ZERO2, 2'b01, 2'b11, 2'b01, 8'd33));
		send_sample(make_sample(OP_SAMPLE, 2'b01, 2'b01, 2'b10, 8'd67));
	endtask

	task automatic test_travel_limits();
		// counts end up above the new maxima
		set_travel(16'd2, 16'd0);
		send_sample(make_sample(OP_IGNORED, last1, last2, 2'b00, 8'd100));
		send_sample(make_sample(OP_SAMPLE, last1, last2, 2'b11, 8'd100));
		send_sample(make_sample(OP_ZERO2, 2'b11, 2'b11, 2'b01, 8'd100));
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b1), last2, 2'b10, 8'd255));
		set_travel(16'd0, 16'hFFFF);
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b1),
			phase_after(last2, 1'b1), 2'b00, 8'd100));
		send_sample(make_sample(OP_ZERO1, 2'b00, 2'b00, 2'b11, 8'd77));
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b0),
			phase_after(last2, 1'b1), 2'b01, 8'd255));
		set_travel(16'd1, 16'd65534);
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b1),
			phase_after(last2, 1'b1), 2'b10, 8'd100));
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b1),
			phase_after(last2, 1'b0), 2'b11, 8'd99));
		send_sample(make_sample(OP_ZERO1, 2'b10, 2'b10, 2'b00, 8'd100));
		send_sample(make_sample(OP_ZERO2, 2'b01, 2'b10, 2'b00, 8'd3));
		send_sample(make_sample(OP_SAMPLE, phase_after(last1, 1'b0),
			phase_after(last2, 1'b0), 2'b01, 8'd128));
	endtask

	task automatic test_output_backpressure();
		quiesce();
		hold_len = HOLD_CYCLES;
		tx_gaps = 1'b0;
		repeat (20) send_sample(motion_sample(1'b1, 1'b0));
		tx_gaps = 1'b1;
		quiesce();
	endtask

	task automatic test_random_motion();
		logic [15:0] a, b;
		logic up1, up2;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin a = 16'd1; b = 16'd65534; end
				1: begin a = 16'd65534; b = 16'd1; end
				2: begin a = 16'd0; b = 16'hFFFF; end
				3: begin a = 16'($urandom_range(2, 40)); b = 16'($urandom_range(2, 40)); end
				4: begin a = 16'($urandom); b = 16'($urandom_range(1, 12)); end
				5: begin a = 16'($urandom_range(1, 8)); b = 16'($urandom_range(100, 65535)); end
				default: begin a = MAX_RESET; b = 16'($urandom); end
			endcase
			set_travel(a, b);
			tx_gaps = ($urandom_range(0, 3) != 0);
			rx_gaps = ($urandom_range(0, 3) != 0);
			up1 = 1'($urandom);
			up2 = 1'($urandom);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ($urandom_range(0, 39) == 0) up1 = ~up1;
				if ($urandom_range(0, 39) == 0) up2 = ~up2;
				send_sample(motion_sample(up1, up2));
			end
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_A;
		cfg_data = 16'd0;
		s_tvalid = 1'b0;
		s_tdata = 16'd0;
		s_tuser = OP_SAMPLE;
		max_a = MAX_RESET;
		max_b = MAX_RESET;
		pos1 = 16'd1;
		pos2 = 16'd1;
		last1 = 2'b00;
		last2 = 2'b00;
		glitch_cnt = 16'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_phase_table();
		test_travel_limits();
		test_output_backpressure();
		test_random_motion();

		quiesce();
		if (errors == 0)
			$display("dual_quadrature_decoder regression: pass");
		else
			$display("dual_quadrature_decoder regression: fail");
		$finish;
	end

	// result side: random stalls per word, one long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(negedge clk);
				hold_len = 0;
			end
			stall = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(arst_n && m_tvalid)) @(posedge clk);
		end
	end

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		position_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected word, expected none actual %h", $time, m_tdata);
				errors++;
			end else begin
				want = expected_q.pop_front();
				check_field("count_one", want.cnt1, got.cnt1);
				check_field("count_two", want.cnt2, got.cnt2);
				check_field("percent_one", want.pct1, got.pct1);
				check_field("percent_two", want.pct2, got.pct2);
				check_field("glitch_total", want.glitches, got.glitches);
				check_field("at_limit_one", want.lim1, got.lim1);
				check_field("at_limit_two", want.lim2, got.lim2);
				check_field("target_count_one", want.tgt1, got.tgt1);
				check_field("target_count_two", want.tgt2, got.tgt2);
			end
		end
	end

	// no word moving on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("dual_quadrature_decoder regression: fail");
				$finish;
			end
		end
	end

endmodule
